### sv/tjcs_pkg.sv
package tjcs_pkg;

  // Default number of arm joints served by the selector.
  localparam int NUM_JOINTS_DEF = 5;

  // Fixed field widths.
  localparam int AXIS_W  = 16;
  localparam int VEL_W   = 26;
  localparam int JVEL_W  = 18;
  localparam int JOINT_W = 3;

  // Shared multiplier: operand width and the width of a shifted magnitude.
  localparam int OPA_W  = 21;
  localparam int PROD_W = 2 * OPA_W;
  localparam int MAG_W  = 26;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register index, taken from the word address.
  typedef enum logic [2:0] {
    REG_LINEAR_GAIN    = 3'd0,
    REG_ANGULAR_GAIN   = 3'd1,
    REG_QUADRATIC_MODE = 3'd2,
    REG_TIMEOUT_TICKS  = 3'd3,
    REG_BASE_DEAD_BAND = 3'd4,
    REG_ARM_DEAD_BAND  = 3'd5,
    REG_JOINT_SPEED    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic        quadratic_mode;
    logic [15:0] timeout_ticks;
    logic [15:0] base_dead_band;
    logic [15:0] arm_dead_band;
    logic [15:0] joint_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    linear_gain:    16'd4096,
    angular_gain:   16'd4096,
    quadratic_mode: 1'b1,
    timeout_ticks:  16'd25,
    base_dead_band: 16'd66,
    arm_dead_band:  16'd655,
    joint_speed:    16'd11438
  };

  // Right shift applied to the product.
  typedef enum logic [1:0] {
    SH_11,
    SH_12,
    SH_15,
    SH_16
  } sh_t;

  typedef struct packed {
    logic             load;
    logic [OPA_W-1:0] a;
    logic [OPA_W-1:0] b;
    sh_t              sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LX,
    ST_LY,
    ST_AZ,
    ST_QX,
    ST_QY,
    ST_QZ,
    ST_JV,
    ST_FIN
  } state_t;

endpackage

### sv/tjcs_joy_if.sv
interface tjcs_joy_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        deadman;
  logic signed [15:0] stick_forward;
  logic signed [15:0] stick_sideways;
  logic signed [15:0] left_trigger;
  logic signed [15:0] right_trigger;
  logic signed [15:0] joint_select;
  logic signed [15:0] joint_stick;
  logic        grip_close_button;
  logic        grip_open_button;

  modport source (
    output valid, kind, deadman, stick_forward, stick_sideways, left_trigger,
           right_trigger, joint_select, joint_stick, grip_close_button, grip_open_button,
    input  ready
  );

  modport sink (
    input  valid, kind, deadman, stick_forward, stick_sideways, left_trigger,
           right_trigger, joint_select, joint_stick, grip_close_button, grip_open_button,
    output ready
  );
endinterface

### sv/tjcs_cmd_if.sv
interface tjcs_cmd_if;
  logic        valid;
  logic        ready;
  logic        base_send;
  logic signed [25:0] linear_x;
  logic signed [25:0] linear_y;
  logic signed [25:0] angular_z;
  logic        arm_send;
  logic [2:0]  arm_joint;
  logic signed [17:0] joint_velocity;
  logic        grip_send;
  logic        grip_open;

  modport source (
    output valid, base_send, linear_x, linear_y, angular_z, arm_send, arm_joint,
           joint_velocity, grip_send, grip_open,
    input  ready
  );

  modport sink (
    input  valid, base_send, linear_x, linear_y, angular_z, arm_send, arm_joint,
           joint_velocity, grip_send, grip_open,
    output ready
  );
endinterface

### sv/tjcs_regs.sv
module tjcs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tjcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [tjcs_pkg::DATA_W-1:0]   pwdata,
  output logic [tjcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tjcs_pkg::cfg_t                cfg
);

  tjcs_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = tjcs_pkg::reg_idx_t'(paddr[tjcs_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase; unmapped addresses are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tjcs_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        tjcs_pkg::REG_LINEAR_GAIN:    cfg.linear_gain    <= pwdata[15:0];
        tjcs_pkg::REG_ANGULAR_GAIN:   cfg.angular_gain   <= pwdata[15:0];
        tjcs_pkg::REG_QUADRATIC_MODE: cfg.quadratic_mode <= pwdata[0];
        tjcs_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[15:0];
        tjcs_pkg::REG_BASE_DEAD_BAND: cfg.base_dead_band <= pwdata[15:0];
        tjcs_pkg::REG_ARM_DEAD_BAND:  cfg.arm_dead_band  <= pwdata[15:0];
        tjcs_pkg::REG_JOINT_SPEED:    cfg.joint_speed    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (idx)
      tjcs_pkg::REG_LINEAR_GAIN:    prdata = 32'(cfg.linear_gain);
      tjcs_pkg::REG_ANGULAR_GAIN:   prdata = 32'(cfg.angular_gain);
      tjcs_pkg::REG_QUADRATIC_MODE: prdata = 32'(cfg.quadratic_mode);
      tjcs_pkg::REG_TIMEOUT_TICKS:  prdata = 32'(cfg.timeout_ticks);
      tjcs_pkg::REG_BASE_DEAD_BAND: prdata = 32'(cfg.base_dead_band);
      tjcs_pkg::REG_ARM_DEAD_BAND:  prdata = 32'(cfg.arm_dead_band);
      tjcs_pkg::REG_JOINT_SPEED:    prdata = 32'(cfg.joint_speed);
      default:                      prdata = '0;
    endcase
  end

endmodule

### sv/tjcs_mul.sv
module tjcs_mul (
  input  logic                        clk,
  input  tjcs_pkg::mul_req_t          req,
  output logic [tjcs_pkg::MAG_W-1:0]  res
);

  logic [tjcs_pkg::PROD_W-1:0] prod;
  tjcs_pkg::sh_t               sh_q;

  // Unsigned product is registered together with its scaling.
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= req.a * req.b;
      sh_q <= req.sh;
    end
  end

  // Truncating right shift by one of a few fixed amounts.
  always_comb begin
    case (sh_q)
      tjcs_pkg::SH_11: res = prod[11 +: tjcs_pkg::MAG_W];
      tjcs_pkg::SH_12: res = prod[12 +: tjcs_pkg::MAG_W];
      tjcs_pkg::SH_15: res = prod[15 +: tjcs_pkg::MAG_W];
      tjcs_pkg::SH_16: res = prod[16 +: tjcs_pkg::MAG_W];
      default:         res = prod[11 +: tjcs_pkg::MAG_W];
    endcase
  end

endmodule

### sv/tjcs_ctrl.sv
module tjcs_ctrl #(
  parameter int NUM_JOINTS = tjcs_pkg::NUM_JOINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tjcs_pkg::cfg_t              cfg,
  tjcs_joy_if.sink                    joy,
  tjcs_cmd_if.source                  cmd,
  output tjcs_pkg::mul_req_t          mul_req,
  input  logic [tjcs_pkg::MAG_W-1:0]  mul_res
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);
  localparam int MW = tjcs_pkg::MAG_W;
  localparam int AW = tjcs_pkg::OPA_W;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(~e + 17'd1) : e;
  endfunction

  tjcs_pkg::state_t state, state_next;

  // Latched word.
  logic               item_kind, item_deadman, item_gc, item_go;
  logic signed [15:0] item_fwd, item_side, item_lt, item_rt, item_sel, item_js;

  // Intermediate magnitudes.
  logic [MW-1:0] lx_m, ly_m, az_m;

  // Persistent control state.
  logic          left_armed, right_armed, control_active, base_halted, arm_halted;
  logic          sel_released;
  logic [JW-1:0] sel_joint;
  logic [15:0]   ticks;

  // Output register.
  logic                      out_valid;
  logic                      out_base_send, out_arm_send, out_grip_send, out_grip_open;
  logic [tjcs_pkg::VEL_W-1:0]   out_lx, out_ly, out_az;
  logic [tjcs_pkg::JOINT_W-1:0] out_joint;
  logic [tjcs_pkg::JVEL_W-1:0]  out_jv;

  logic fin_go;
  logic accept;

  // Turn selection from the triggers.
  logic        left_arm_eff, right_arm_eff;
  logic [17:0] lturn_full, rturn_full;
  logic [16:0] lturn, rturn, band17, turn_mag;
  logic        turn_left, turn_right;
  logic        lx_neg, ly_neg, jv_neg;

  assign accept        = joy.valid && joy.ready;
  assign left_arm_eff  = left_armed || (item_lt != 16'sd0);
  assign right_arm_eff = right_armed || (item_rt != 16'sd0);
  assign lturn_full    = 18'h08000 - {{2{item_lt[15]}}, item_lt};
  assign rturn_full    = 18'h08000 - {{2{item_rt[15]}}, item_rt};
  assign lturn         = left_arm_eff ? lturn_full[16:0] : '0;
  assign rturn         = right_arm_eff ? rturn_full[16:0] : '0;
  assign band17        = {1'b0, cfg.base_dead_band};
  assign turn_left     = (lturn > band17) && (rturn < band17);
  assign turn_right    = (rturn > band17) && (lturn < band17);
  assign turn_mag      = turn_left ? lturn : (turn_right ? rturn : '0);
  assign lx_neg        = item_fwd[15];
  assign ly_neg        = item_side[15];
  assign jv_neg        = !item_js[15] && (item_js != 16'sd0);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tjcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the multiplier request of each step.
  always_comb begin
    state_next = state;
    joy.ready  = 1'b0;
    fin_go     = 1'b0;
    mul_req    = '{load: 1'b0, a: '0, b: '0, sh: tjcs_pkg::SH_11};
    case (state)
      tjcs_pkg::ST_IDLE: begin
        joy.ready = 1'b1;
        if (joy.valid) begin
          state_next = (!joy.kind && joy.deadman) ? tjcs_pkg::ST_LX : tjcs_pkg::ST_FIN;
        end
      end
      tjcs_pkg::ST_LX: begin
        mul_req    = '{load: 1'b1, a: AW'(abs16(item_fwd)), b: AW'(cfg.linear_gain),
                       sh: tjcs_pkg::SH_11};
        state_next = tjcs_pkg::ST_LY;
      end
      tjcs_pkg::ST_LY: begin
        mul_req    = '{load: 1'b1, a: AW'(abs16(item_side)), b: AW'(cfg.linear_gain),
                       sh: tjcs_pkg::SH_11};
        state_next = tjcs_pkg::ST_AZ;
      end
      tjcs_pkg::ST_AZ: begin
        mul_req    = '{load: 1'b1, a: AW'(turn_mag), b: AW'(cfg.angular_gain),
                       sh: tjcs_pkg::SH_12};
        state_next = cfg.quadratic_mode ? tjcs_pkg::ST_QX : tjcs_pkg::ST_JV;
      end
      tjcs_pkg::ST_QX: begin
        mul_req    = '{load: 1'b1, a: lx_m[AW-1:0], b: lx_m[AW-1:0], sh: tjcs_pkg::SH_16};
        state_next = tjcs_pkg::ST_QY;
      end
      tjcs_pkg::ST_QY: begin
        mul_req    = '{load: 1'b1, a: ly_m[AW-1:0], b: ly_m[AW-1:0], sh: tjcs_pkg::SH_16};
        state_next = tjcs_pkg::ST_QZ;
      end
      tjcs_pkg::ST_QZ: begin
        mul_req    = '{load: 1'b1, a: az_m[AW-1:0], b: az_m[AW-1:0], sh: tjcs_pkg::SH_16};
        state_next = tjcs_pkg::ST_JV;
      end
      tjcs_pkg::ST_JV: begin
        mul_req    = '{load: 1'b1, a: AW'(abs16(item_js)), b: AW'(cfg.joint_speed),
                       sh: tjcs_pkg::SH_15};
        state_next = tjcs_pkg::ST_FIN;
      end
      tjcs_pkg::ST_FIN: begin
        fin_go = !out_valid || cmd.ready;
        if (fin_go) begin
          state_next = tjcs_pkg::ST_IDLE;
        end
      end
      default: state_next = tjcs_pkg::ST_IDLE;
    endcase
  end

  // Result and state update of the finished word.
  logic                         res_base_send, res_arm_send, res_grip_send, res_grip_open;
  logic [tjcs_pkg::VEL_W-1:0]   res_lx, res_ly, res_az;
  logic [tjcs_pkg::JOINT_W-1:0] res_joint;
  logic [tjcs_pkg::JVEL_W-1:0]  res_jv;
  logic                         ca_next, bh_next, ah_next, la_next, ra_next, sr_next;
  logic [JW-1:0]                sj_next;
  logic [15:0]                  tk_next;

  always_comb begin
    logic          base_go;
    logic          rel;
    logic [MW-1:0] band_m;
    logic [MW-1:0] jv_m;
    base_go       = 1'b0;
    rel           = 1'b0;
    band_m        = MW'(cfg.base_dead_band);
    jv_m          = mul_res;
    res_base_send = 1'b0;
    res_arm_send  = 1'b0;
    res_grip_send = 1'b0;
    res_grip_open = 1'b0;
    res_lx        = '0;
    res_ly        = '0;
    res_az        = '0;
    res_joint     = '0;
    res_jv        = '0;
    ca_next       = control_active;
    bh_next       = base_halted;
    ah_next       = arm_halted;
    la_next       = left_armed;
    ra_next       = right_armed;
    sr_next       = sel_released;
    sj_next       = sel_joint;
    tk_next       = ticks;
    if (item_kind) begin
      // Watchdog tick: saturating count, stop once past the timeout.
      tk_next = (ticks != 16'hFFFF) ? ticks + 16'd1 : ticks;
      if ((tk_next > cfg.timeout_ticks) && control_active) begin
        if (!base_halted) begin
          res_base_send = 1'b1;
          bh_next       = 1'b1;
        end
        if (!arm_halted) begin
          res_arm_send = 1'b1;
          ah_next      = 1'b1;
        end
      end
    end else if (!item_deadman) begin
      // First released sample after active control stops the base and the arm.
      if (control_active) begin
        ca_next = 1'b0;
        if (!base_halted) begin
          res_base_send = 1'b1;
          bh_next       = 1'b1;
        end
        if (!arm_halted) begin
          res_arm_send = 1'b1;
          ah_next      = 1'b1;
        end
      end
    end else begin
      ca_next = 1'b1;
      la_next = left_arm_eff;
      ra_next = right_arm_eff;
      tk_next = '0;

      // Base command above the dead band, otherwise a single stop.
      base_go = (lx_m > band_m) || (ly_m > band_m) || (az_m > band_m);
      if (base_go) begin
        res_base_send = 1'b1;
        res_lx        = lx_neg ? (MW'(0) - lx_m) : lx_m;
        res_ly        = ly_neg ? (MW'(0) - ly_m) : ly_m;
        res_az        = turn_right ? (MW'(0) - az_m) : az_m;
        bh_next       = 1'b0;
      end else if (!base_halted) begin
        res_base_send = 1'b1;
        bh_next       = 1'b1;
      end

      // Joint selector steps once per release of the axis.
      rel = sel_released || ((item_sel <= 16'sd16384) && (item_sel >= -16'sd16384));
      if ((item_sel > 16'sd16384) && rel) begin
        if (sel_joint < LAST_JOINT) begin
          sj_next = sel_joint + JW'(1);
        end
        sr_next = 1'b0;
      end else if ((item_sel < -16'sd16384) && rel) begin
        if (sel_joint != '0) begin
          sj_next = sel_joint - JW'(1);
        end
        sr_next = 1'b0;
      end else begin
        sr_next = rel;
      end

      // Arm command for the selected joint.
      if (jv_m > MW'(cfg.arm_dead_band)) begin
        res_arm_send = 1'b1;
        res_joint    = tjcs_pkg::JOINT_W'(sj_next);
        res_jv       = tjcs_pkg::JVEL_W'(jv_neg ? (MW'(0) - jv_m) : jv_m);
        ah_next      = 1'b0;
      end else if (!arm_halted) begin
        res_arm_send = 1'b1;
        ah_next      = 1'b1;
      end

      // Gripper, close wins over open.
      if (item_gc) begin
        res_grip_send = 1'b1;
        res_grip_open = 1'b0;
      end else if (item_go) begin
        res_grip_send = 1'b1;
        res_grip_open = 1'b1;
      end
    end
  end

  // Latch the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind    <= joy.kind;
      item_deadman <= joy.deadman;
      item_fwd     <= joy.stick_forward;
      item_side    <= joy.stick_sideways;
      item_lt      <= joy.left_trigger;
      item_rt      <= joy.right_trigger;
      item_sel     <= joy.joint_select;
      item_js      <= joy.joint_stick;
      item_gc      <= joy.grip_close_button;
      item_go      <= joy.grip_open_button;
    end
  end

  // Collect multiplier results one step after each issue.
  always_ff @(posedge clk) begin
    case (state)
      tjcs_pkg::ST_LY: lx_m <= mul_res;
      tjcs_pkg::ST_AZ: ly_m <= mul_res;
      tjcs_pkg::ST_QX: az_m <= mul_res;
      tjcs_pkg::ST_QY: lx_m <= mul_res;
      tjcs_pkg::ST_QZ: ly_m <= mul_res;
      tjcs_pkg::ST_JV: az_m <= mul_res;
      default: ;
    endcase
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_armed     <= 1'b0;
      right_armed    <= 1'b0;
      control_active <= 1'b0;
      base_halted    <= 1'b0;
      arm_halted     <= 1'b0;
      sel_released   <= 1'b1;
      sel_joint      <= '0;
      ticks          <= '0;
      out_valid      <= 1'b0;
    end else if (fin_go) begin
      left_armed     <= la_next;
      right_armed    <= ra_next;
      control_active <= ca_next;
      base_halted    <= bh_next;
      arm_halted     <= ah_next;
      sel_released   <= sr_next;
      sel_joint      <= sj_next;
      ticks          <= tk_next;
      out_valid      <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_base_send <= res_base_send;
      out_lx        <= res_lx;
      out_ly        <= res_ly;
      out_az        <= res_az;
      out_arm_send  <= res_arm_send;
      out_joint     <= res_joint;
      out_jv        <= res_jv;
      out_grip_send <= res_grip_send;
      out_grip_open <= res_grip_open;
    end
  end

  assign cmd.valid          = out_valid;
  assign cmd.base_send      = out_base_send;
  assign cmd.linear_x       = out_lx;
  assign cmd.linear_y       = out_ly;
  assign cmd.angular_z      = out_az;
  assign cmd.arm_send       = out_arm_send;
  assign cmd.arm_joint      = out_joint;
  assign cmd.joint_velocity = out_jv;
  assign cmd.grip_send      = out_grip_send;
  assign cmd.grip_open      = out_grip_open;

  // An accepted word always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != tjcs_pkg::ST_IDLE))
    else $error("sequencer stayed idle after an accepted word");

  // No velocity is shown without a base command.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_base_send) |-> ((out_lx == '0) && (out_ly == '0) && (out_az == '0)))
    else $error("base velocity present without base command");

  // A finished deadman sample leaves control active and the watchdog cleared.
  assert property (@(posedge clk) disable iff (rst)
    (fin_go && !item_kind && item_deadman) |=> (control_active && (ticks == '0)))
    else $error("deadman sample did not refresh control state");

  // The first and last squaring steps (QX, QZ) run only in quadratic mode.
  assert property (@(posedge clk) disable iff (rst)
    ((state == tjcs_pkg::ST_QX) || (state == tjcs_pkg::ST_QZ)) |-> cfg.quadratic_mode)
    else $error("squaring step outside quadratic mode");

  // The selected joint stays within the configured joint count.
  assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (sel_joint <= LAST_JOINT))
    else $error("selected joint out of range");

endmodule

### sv/teleop_joystick_command_shaper_top.sv
// Joystick command shaper for a teleoperated mobile manipulator.
// Words enter on the joy channel (valid/ready): either a joystick sample
// or a watchdog tick. Every word yields exactly one word on the cmd channel
// carrying the base, arm and gripper commands with their send flags.
// Gains, dead bands, joint speed, timeout and squaring mode are set through
// the APB port while the block is idle; the user must keep to this, as the
// block itself does not enforce it. pready is always high.
// All products run through one shared multiplier under a small sequencer.
// A sample with the deadman held issues one multiply per cycle: three for
// the base, three more for squaring in quadratic mode, one for the arm.
// A tick or a released-deadman sample goes straight to the finishing state.
// joy ready is high only while the sequencer is idle, so a new word is not
// taken until the previous one has finished.
// The result sits in an output register; a new word may be accepted while
// it waits, but that word cannot finish until cmd has drained.
// Synchronous reset restores the register defaults, clears the trigger
// arming, halt flags and watchdog count, and selects joint zero.
module teleop_joystick_command_shaper_top #(
  parameter int NUM_JOINTS = tjcs_pkg::NUM_JOINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  tjcs_joy_if.sink                     joy,
  tjcs_cmd_if.source                   cmd,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tjcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [tjcs_pkg::DATA_W-1:0]  pwdata,
  output logic [tjcs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  tjcs_pkg::cfg_t              cfg;
  tjcs_pkg::mul_req_t          mul_req;
  logic [tjcs_pkg::MAG_W-1:0]  mul_res;

  tjcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tjcs_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  tjcs_ctrl #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .joy     (joy),
    .cmd     (cmd),
    .mul_req (mul_req),
    .mul_res (mul_res)
  );

endmodule
